// ----- src/wcc_pkg.sv -----
// shared types, widths and codes for the windowed coincidence counter
package wcc_pkg;

    localparam int TS_W       = 63;
    localparam int CH_W       = 8;
    localparam int CNT_W      = 32;
    localparam int N_CURVES   = 3;
    localparam int N_SIDES    = 2 * N_CURVES;
    localparam int FUNC_W     = 2;
    localparam int OFFSET_W   = 32;
    localparam int WIN_W      = 64;
    localparam int DELAY_W    = 64;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;
    localparam int S_DATA_W   = 72;
    localparam int M_DATA_W   = N_CURVES * CNT_W;

    localparam logic [FUNC_W-1:0] FUNC_EVENT  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_END    = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_REPORT = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_SETUP = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HIST_OFFSET   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_C0_A   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_C0_B   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_C1_A   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_C1_B   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_C2_A   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_C2_B   = 3'd7;

    // layout matches the channel_setup register, msb first
    typedef struct packed {
        logic [N_SIDES-1:0] use_b;
        logic [CH_W-1:0]    ch_b;
        logic [CH_W-1:0]    ch_a;
        logic [CH_W-1:0]    ch_start;
    } t_chan_setup;

    typedef logic [N_SIDES-1:0][WIN_W-1:0] t_windows;

endpackage

// ----- src/wcc_match.sv -----
// delay computation and window compare for the six curve sides
module wcc_match
    import wcc_pkg::*;
(
    input  logic [TS_W-1:0]     i_ts,
    input  logic [CH_W-1:0]     i_ch,
    input  logic [TS_W-1:0]     i_start,
    input  logic [OFFSET_W-1:0] i_offset,
    input  t_chan_setup         i_setup,
    input  t_windows            i_windows,
    output logic [N_SIDES-1:0]  o_hits
);

    logic [DELAY_W-1:0] w_delay;
    logic [DELAY_W-1:0] w_lo [N_SIDES];
    logic [DELAY_W-1:0] w_hi [N_SIDES];
    logic [CH_W-1:0]    w_want [N_SIDES];

    // delay wraps modulo 2^64 and is then read as signed
    assign w_delay = {1'b0, i_ts} - {1'b0, i_start}
                   + {{(DELAY_W-OFFSET_W){i_offset[OFFSET_W-1]}}, i_offset};

    always_comb begin
        for (int k = 0; k < N_SIDES; k++) begin
            w_want[k] = i_setup.use_b[k] ? i_setup.ch_b : i_setup.ch_a;
            w_lo[k]   = {{(DELAY_W-32){i_windows[k][31]}}, i_windows[k][31:0]};
            w_hi[k]   = {{(DELAY_W-32){i_windows[k][63]}}, i_windows[k][63:32]};
            o_hits[k] = (i_ch == w_want[k])
                      && ($signed(w_lo[k]) < $signed(w_delay))
                      && ($signed(w_delay) < $signed(w_hi[k]));
        end
    end

endmodule

// ----- src/windowed_coincidence_counter_unit.sv -----
// windowed coincidence counter: time-tag events in, curve counts out
//
// slave stream carries one transaction per item: tuser is the function
// (event, end of batch, report), tdata holds timestamp and channel.
// a start-channel event opens a coincidence window; later events that fall
// inside a curve side's delay window set that side's hit flag, and closing
// the window bumps each curve whose two sides both hit.
// a report transaction returns the three 32-bit counts on the master stream
// and clears them; other functions give no result.
// an item is taken into an input register, worked on by one pass of compare
// and update logic once the result register is free or being read, and a
// report lands in the result register at the end of that pass.
// one item per cycle is accepted as long as the master side keeps up; while
// a report waits with i_m_tready low, the input register holds and
// o_s_tready drops once it is full.
// the config channel is always ready; writes belong in idle periods.
// reset clears the config and valid registers, window, hit flags and counts.
module windowed_coincidence_counter_unit
    import wcc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // slave stream
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [S_DATA_W-1:0]   i_s_tdata,   // timestamp[62:0], channel[70:63], zero
    input  logic [FUNC_W-1:0]     i_s_tuser,   // func[1:0]
    // master stream
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [M_DATA_W-1:0]   o_m_tdata,   // count_curve0, count_curve1, count_curve2
    // config write channel
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    // configuration
    t_chan_setup          r_setup;
    logic [OFFSET_W-1:0]  r_offset;
    t_windows             r_windows;

    // input register
    logic                 r_in_valid;
    logic [FUNC_W-1:0]    r_func;
    logic [TS_W-1:0]      r_ts;
    logic [CH_W-1:0]      r_ch;

    // window state
    logic                 r_win_open, n_win_open;
    logic [TS_W-1:0]      r_start, n_start;
    logic [N_SIDES-1:0]   r_side_hits, n_side_hits;
    logic [N_CURVES-1:0][CNT_W-1:0] r_count, n_count;

    // result register
    logic                 r_out_valid;
    logic [M_DATA_W-1:0]  r_out_data;

    logic                 w_proceed;
    logic                 w_close;
    logic [N_SIDES-1:0]   w_hits;

    assign o_cfg_ready = 1'b1;
    assign w_proceed   = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready  = !r_in_valid || w_proceed;
    assign o_m_tvalid  = r_out_valid;
    assign o_m_tdata   = r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_setup   <= '0;
            r_offset  <= '0;
            r_windows <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index) inside
                REG_CHANNEL_SETUP: r_setup  <= i_cfg_data[$bits(t_chan_setup)-1:0];
                REG_HIST_OFFSET:   r_offset <= i_cfg_data[OFFSET_W-1:0];
                REG_WINDOW_C0_A, REG_WINDOW_C0_B, REG_WINDOW_C1_A,
                REG_WINDOW_C1_B, REG_WINDOW_C2_A, REG_WINDOW_C2_B: begin
                    r_windows[i_cfg_index - REG_WINDOW_C0_A] <= i_cfg_data;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_s_tvalid && o_s_tready) begin
            r_in_valid <= 1'b1;
        end else if (w_proceed) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_tvalid && o_s_tready) begin
            r_func <= i_s_tuser;
            r_ts   <= i_s_tdata[TS_W-1:0];
            r_ch   <= i_s_tdata[TS_W +: CH_W];
        end
    end

    wcc_match u_match (
        .i_ts      (r_ts),
        .i_ch      (r_ch),
        .i_start   (r_start),
        .i_offset  (r_offset),
        .i_setup   (r_setup),
        .i_windows (r_windows),
        .o_hits    (w_hits)
    );

    always_comb begin
        n_win_open  = r_win_open;
        n_start     = r_start;
        n_side_hits = r_side_hits;
        n_count     = r_count;
        w_close     = 1'b0;
        if (w_proceed) begin
            case (r_func)
                FUNC_EVENT: begin
                    if (r_ch == r_setup.ch_start) begin
                        w_close = 1'b1;
                    end else if (r_win_open) begin
                        n_side_hits = r_side_hits | w_hits;
                    end
                end
                FUNC_END:    w_close = 1'b1;
                FUNC_REPORT: n_count = '0;
                default: ;
            endcase
        end
        if (w_close) begin
            for (int c = 0; c < N_CURVES; c++) begin
                if (r_win_open && (r_side_hits[2*c +: 2] == 2'b11)
                    && (r_count[c] != {CNT_W{1'b1}})) begin
                    n_count[c] = r_count[c] + 1'b1;
                end
            end
            n_side_hits = '0;
            n_win_open  = 1'b0;
            // a start event reopens at its own timestamp
            if (r_func == FUNC_EVENT) begin
                n_win_open = 1'b1;
                n_start    = r_ts;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_open  <= 1'b0;
            r_start     <= '0;
            r_side_hits <= '0;
            r_count     <= '0;
        end else begin
            r_win_open  <= n_win_open;
            r_start     <= n_start;
            r_side_hits <= n_side_hits;
            r_count     <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_proceed && (r_func == FUNC_REPORT)) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_proceed && (r_func == FUNC_REPORT)) begin
            r_out_data <= r_count;
        end
    end

`ifndef SYNTH
    a_hits_need_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_win_open |-> (r_side_hits == '0))
        else $error("hit flags set with no window open");

    a_report_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_proceed && (r_func == FUNC_REPORT)) |=> (o_m_tvalid && (r_count == '0)))
        else $error("report did not present result and clear counts");

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> (r_in_valid && r_out_valid && !i_m_tready))
        else $error("input stalled without a blocked result");
`endif

endmodule
